/* rtl/core/rational_fraction_alu_macros.svh */
// Assertion macros for the rational fraction ALU.
`ifndef RATIONAL_FRACTION_ALU_MACROS_SVH
`define RATIONAL_FRACTION_ALU_MACROS_SVH

`ifndef NO_ASSERTIONS
`define RFA_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfa assertion failed");
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfa assertion failed");
`else
`define RFA_ASSERT_IMPL(label, clk, rst, ante, cons)
`define RFA_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/rfa_pkg.sv */
`default_nettype none

package rfa_pkg;

  localparam int OPW = 16;        // operand width
  localparam int WW  = 2 * OPW;   // work width for products and sums
  localparam int NW  = 33;        // result numerator width
  localparam int DW  = 31;        // result denominator width
  localparam int KW  = $clog2(WW);

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_CMP = 2'd3;

  typedef struct packed {
    logic load_in;
    logic load_a;
    logic load_b;
    logic load_r;
    logic set_zero;
    logic gcd_init;
    logic even_step;
    logic gcd_step;
    logic div_init;
    logic div_step;
    logic store_a;
    logic store_b;
    logic mul;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic wn_zero;
    logic both_even;
    logic gx_zero;
    logic is_cmp;
  } stat_t;

endpackage

`default_nettype wire

/* rtl/core/rfa_in_if.sv */
`default_nettype none

interface rfa_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     kind;
  logic signed [rfa_pkg::OPW-1:0] a_num;
  logic signed [rfa_pkg::OPW-1:0] a_den;
  logic signed [rfa_pkg::OPW-1:0] b_num;
  logic signed [rfa_pkg::OPW-1:0] b_den;

  modport source (output valid, kind, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, kind, a_num, a_den, b_num, b_den, output ready);
endinterface

`default_nettype wire

/* rtl/core/rfa_out_if.sv */
`default_nettype none

interface rfa_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [rfa_pkg::NW-1:0] res_num;
  logic [rfa_pkg::DW-1:0]        res_den;
  logic                          equal;
  logic                          bad_den;

  modport source (output valid, res_num, res_den, equal, bad_den, input ready);
  modport sink (input valid, res_num, res_den, equal, bad_den, output ready);
endinterface

`default_nettype wire

/* rtl/core/rfa_datapath.sv */
`default_nettype none

module rfa_datapath (
  input  wire logic                           clk,
  input  wire rfa_pkg::cmd_t                  cmd,
  output rfa_pkg::stat_t                      stat,
  input  wire logic [1:0]                     kind,
  input  wire logic signed [rfa_pkg::OPW-1:0] a_num,
  input  wire logic signed [rfa_pkg::OPW-1:0] a_den,
  input  wire logic signed [rfa_pkg::OPW-1:0] b_num,
  input  wire logic signed [rfa_pkg::OPW-1:0] b_den,
  output logic signed [rfa_pkg::NW-1:0]       res_num,
  output logic [rfa_pkg::DW-1:0]              res_den,
  output logic                                equal,
  output logic                                bad_den
);

  localparam int OPW = rfa_pkg::OPW;
  localparam int WW  = rfa_pkg::WW;
  localparam int NW  = rfa_pkg::NW;
  localparam int DW  = rfa_pkg::DW;
  localparam int KW  = rfa_pkg::KW;

  logic [1:0]     kind_r;
  logic [OPW-1:0] an, ad, bn, bd;
  logic           a_neg, b_neg, bad;
  logic [WW-1:0]  wn, wd;
  logic           wneg;
  logic [WW-1:0]  gx, gy;
  logic [KW-1:0]  gk;
  logic [WW-1:0]  dv, rem_n, rem_d, qn, qd;
  logic           qneg;
  logic [WW-1:0]  p, q, dd;

  logic [WW:0]    sh_n, sh_d;
  logic           ge_n, ge_d;
  logic           q_sgn;
  logic [WW-1:0]  comb_n;
  logic           comb_neg;

  function automatic logic [OPW-1:0] mag(input logic [OPW-1:0] v);
    mag = v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    sh_n = {rem_n, qn[WW-1]};
    sh_d = {rem_d, qd[WW-1]};
    ge_n = sh_n >= {1'b0, dv};
    ge_d = sh_d >= {1'b0, dv};
  end

  always_comb begin
    q_sgn  = (kind_r == rfa_pkg::KIND_SUB) ? ~b_neg : b_neg;
    if (kind_r == rfa_pkg::KIND_MUL) begin
      comb_n   = p;
      comb_neg = a_neg ^ b_neg;
    end else if (a_neg == q_sgn) begin
      comb_n   = p + q;
      comb_neg = a_neg;
    end else if (p >= q) begin
      comb_n   = p - q;
      comb_neg = a_neg;
    end else begin
      comb_n   = q - p;
      comb_neg = q_sgn;
    end
  end

  always_comb begin
    stat.bad       = bad;
    stat.wn_zero   = (wn == '0);
    stat.both_even = ~gx[0] & ~gy[0];
    stat.gx_zero   = (gx == '0);
    stat.is_cmp    = (kind_r == rfa_pkg::KIND_CMP);
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      kind_r <= kind;
      an     <= mag(a_num);
      ad     <= mag(a_den);
      bn     <= mag(b_num);
      bd     <= mag(b_den);
      a_neg  <= a_num[OPW-1] ^ a_den[OPW-1];
      b_neg  <= b_num[OPW-1] ^ b_den[OPW-1];
      bad    <= (a_den == '0) || (b_den == '0);
    end
    if (cmd.store_a) begin
      an    <= qn[OPW-1:0];
      ad    <= qd[OPW-1:0];
      a_neg <= qneg;
    end
    if (cmd.store_b) begin
      bn    <= qn[OPW-1:0];
      bd    <= qd[OPW-1:0];
      b_neg <= qneg;
    end

    if (cmd.load_a) begin
      wn   <= {{(WW-OPW){1'b0}}, an};
      wd   <= {{(WW-OPW){1'b0}}, ad};
      wneg <= a_neg;
    end else if (cmd.load_b) begin
      wn   <= {{(WW-OPW){1'b0}}, bn};
      wd   <= {{(WW-OPW){1'b0}}, bd};
      wneg <= b_neg;
    end else if (cmd.load_r) begin
      wn   <= comb_n;
      wd   <= dd;
      wneg <= comb_neg;
    end

    if (cmd.mul) begin
      p  <= WW'(an) * WW'((kind_r == rfa_pkg::KIND_MUL) ? bn : bd);
      q  <= WW'(bn) * WW'(ad);
      dd <= WW'(ad) * WW'(bd);
    end

    // binary gcd: strip common twos, then subtract and halve
    if (cmd.gcd_init) begin
      gx <= wn;
      gy <= wd;
      gk <= '0;
    end else if (cmd.even_step) begin
      gx <= gx >> 1;
      gy <= gy >> 1;
      gk <= gk + 1'b1;
    end else if (cmd.gcd_step) begin
      if (!gx[0]) begin
        gx <= gx >> 1;
      end else if (!gy[0]) begin
        gy <= gy >> 1;
      end else if (gx >= gy) begin
        gx <= (gx - gy) >> 1;
      end else begin
        gy <= (gy - gx) >> 1;
      end
    end

    if (cmd.set_zero) begin
      qn   <= '0;
      qd   <= {{(WW-1){1'b0}}, 1'b1};
      qneg <= 1'b0;
    end else if (cmd.div_init) begin
      dv    <= gy << gk;
      rem_n <= '0;
      rem_d <= '0;
      qn    <= wn;
      qd    <= wd;
      qneg  <= wneg;
    end else if (cmd.div_step) begin
      rem_n <= ge_n ? (sh_n[WW-1:0] - dv) : sh_n[WW-1:0];
      rem_d <= ge_d ? (sh_d[WW-1:0] - dv) : sh_d[WW-1:0];
      qn    <= {qn[WW-2:0], ge_n};
      qd    <= {qd[WW-2:0], ge_d};
    end

    if (cmd.finish) begin
      if (bad) begin
        res_num <= '0;
        res_den <= '0;
        equal   <= 1'b0;
        bad_den <= 1'b1;
      end else if (kind_r == rfa_pkg::KIND_CMP) begin
        res_num <= '0;
        res_den <= {{(DW-1){1'b0}}, 1'b1};
        equal   <= (a_neg == b_neg) && (an == bn) && (ad == bd);
        bad_den <= 1'b0;
      end else begin
        res_num <= qneg ? -$signed({{(NW-WW){1'b0}}, qn}) : $signed({{(NW-WW){1'b0}}, qn});
        res_den <= qd[DW-1:0];
        equal   <= 1'b0;
        bad_den <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rfa_ctrl.sv */
`default_nettype none

module rfa_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  wire logic           out_ready,
  input  wire rfa_pkg::stat_t stat,
  output rfa_pkg::cmd_t       cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHK   = 4'd1;
  localparam logic [3:0] S_ZERO  = 4'd2;
  localparam logic [3:0] S_EVEN  = 4'd3;
  localparam logic [3:0] S_GCD   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_STORE = 4'd6;
  localparam logic [3:0] S_MUL   = 4'd7;
  localparam logic [3:0] S_COMB  = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

  localparam int KW = rfa_pkg::KW;

  logic [3:0]    state, state_next;
  logic [1:0]    phase, phase_next;
  logic [KW-1:0] cnt, cnt_next;
  logic          ov, ov_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = ov;

  always_comb begin
    cmd        = '0;
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    ov_next    = ov & ~out_ready;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.bad) begin
          state_next = S_FIN;
        end else begin
          cmd.load_a = 1'b1;
          phase_next = PH_A;
          state_next = S_ZERO;
        end
      end
      S_ZERO: begin
        if (stat.wn_zero) begin
          cmd.set_zero = 1'b1;
          state_next   = S_STORE;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_EVEN;
        end
      end
      S_EVEN: begin
        if (stat.both_even) begin
          cmd.even_step = 1'b1;
        end else begin
          state_next = S_GCD;
        end
      end
      S_GCD: begin
        if (stat.gx_zero) begin
          cmd.div_init = 1'b1;
          cnt_next     = '0;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == '1) begin
          state_next = S_STORE;
        end
      end
      S_STORE: begin
        case (phase)
          PH_A: begin
            cmd.store_a = 1'b1;
            cmd.load_b  = 1'b1;
            phase_next  = PH_B;
            state_next  = S_ZERO;
          end
          PH_B: begin
            cmd.store_b = 1'b1;
            state_next  = stat.is_cmp ? S_FIN : S_MUL;
          end
          default: begin
            state_next = S_FIN;
          end
        endcase
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_COMB;
      end
      S_COMB: begin
        cmd.load_r = 1'b1;
        phase_next = PH_R;
        state_next = S_ZERO;
      end
      S_FIN: begin
        // hold until the output register is free
        if (!ov || out_ready) begin
          cmd.finish = 1'b1;
          ov_next    = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_A;
      cnt   <= '0;
      ov    <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
      ov    <= ov_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/rational_fraction_alu.sv */
// Flow: a zero denominator goes straight to the result; otherwise the result is set by
//   three reductions in sequence (two for a compare), each a binary gcd (one
//   subtract-and-halve a cycle) and a restoring division of numerator and denominator
//   in parallel.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: rst, synchronous active high, returns the controller to idle, output empty.
`default_nettype none
`include "rational_fraction_alu_macros.svh"

module rational_fraction_alu (
  input wire logic clk,
  input wire logic rst,
  rfa_in_if.sink   in_ch,
  rfa_out_if.source out_ch
);

  rfa_pkg::cmd_t  cmd;
  rfa_pkg::stat_t stat;

  rfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rfa_datapath u_dp (
    .clk     (clk),
    .cmd     (cmd),
    .stat    (stat),
    .kind    (in_ch.kind),
    .a_num   (in_ch.a_num),
    .a_den   (in_ch.a_den),
    .b_num   (in_ch.b_num),
    .b_den   (in_ch.b_den),
    .res_num (out_ch.res_num),
    .res_den (out_ch.res_den),
    .equal   (out_ch.equal),
    .bad_den (out_ch.bad_den)
  );

  `RFA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_ch.valid && in_ch.ready, !in_ch.ready)
  `RFA_ASSERT_IMPL(a_bad_clears, clk, rst, out_ch.valid && out_ch.bad_den, out_ch.res_den == '0 && !out_ch.equal)
  `RFA_ASSERT_IMPL(a_equal_form, clk, rst, out_ch.valid && out_ch.equal, out_ch.res_num == '0 && out_ch.res_den == 31'd1)

endmodule

`default_nettype wire
